/* rtl/ms3d_pkg.sv */
package ms3d_pkg;

    // widths fixed by the item format
    localparam int PX_W  = 8;
    localparam int PY_W  = 4;
    localparam int PZ_W  = 6;
    localparam int POS_W = PX_W + PY_W + PZ_W;
    localparam int CW    = 13;   // holds any extent up to 4096
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_RUN   = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_CLAMP = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE_X = 3'd0,
        CFG_SIZE_Y = 3'd1,
        CFG_SIZE_Z = 3'd2,
        CFG_GAIN   = 3'd3,
        CFG_SWEEPS = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_HOST,
        CMD_RD_RESULT,
        CMD_NB,
        CMD_NBL,
        CMD_DIFF,
        CMD_MLO,
        CMD_MHI,
        CMD_UP_RD,
        CMD_UP_WR,
        CMD_RUN_DONE
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HOST_RD,
        S_NB,
        S_NBL,
        S_DIFF,
        S_MLO,
        S_MHI,
        S_UP_RD,
        S_UP_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic    out_free;
        t_action act;
        logic    in_box;
        logic    run_trivial;
        logic    k_last;
        logic    cell_last;
        logic    sweep_last;
    } t_dp_stat;

endpackage

/* rtl/masked_3d_diffusion_stencil.sv */
// Masked 3D diffusion stencil: a grid of Q2.22 concentrations with wall flags.
// Input channel (s_axis): tuser carries the action (write, run, read), tdata the
// coordinate, value and wall flag. One result beat (m_axis) comes back for every
// input beat: read data and a status code.
// Configuration (cfg_*) sets the box extents, gain and sweeps per run; write it
// only while no item is in flight.
// A write is answered from its accept; a read waits on the registered RAM read.
// Each sweep of a run is a gather pass over the interior cells, which reads the
// seven stencil cells through the single read port of the grid RAM and scales
// the delta, then an apply pass that adds the deltas; a done state reports.
// The next item is taken once the current one is answered.
// Reset clears control state and loads the register defaults; grid contents are
// undefined until written, so every in-box cell must be written before a run.
// The result sits in an output register; while the receiver stalls it holds
// and no new item is taken.
module masked_3d_diffusion_stencil #(
    parameter int DIM_X      = 256,
    parameter int DIM_Y      = 16,
    parameter int DIM_Z      = 64,
    parameter int VALUE_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ms3d_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ms3d_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // pos_x, pos_y, pos_z, cell_value, is_wall
    input  logic [((ms3d_pkg::POS_W+VALUE_BITS+1+7)/8)*8-1:0] i_s_axis_tdata,
    // action
    input  logic [1:0]                          i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // read_value, read_wall, status
    output logic [((VALUE_BITS+3+7)/8)*8-1:0]   o_m_axis_tdata
);
    import ms3d_pkg::*;

    localparam int IN_W  = ((POS_W + VALUE_BITS + 1 + 7) / 8) * 8;
    localparam int OUT_W = ((VALUE_BITS + 3 + 7) / 8) * 8;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    ms3d_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    ms3d_datapath #(
        .DIM_X      (DIM_X),
        .DIM_Y      (DIM_Y),
        .DIM_Z      (DIM_Z),
        .VALUE_BITS (VALUE_BITS),
        .IN_W       (IN_W),
        .OUT_W      (OUT_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_s_axis_tdata),
        .i_in_user   (i_s_axis_tuser),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata)
    );
endmodule

/* rtl/ms3d_ram.sv */
module ms3d_ram #(
    parameter int          WIDTH = 8,
    parameter longint unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/ms3d_datapath.sv */
module ms3d_datapath #(
    parameter int DIM_X      = 256,
    parameter int DIM_Y      = 16,
    parameter int DIM_Z      = 64,
    parameter int VALUE_BITS = 24,
    parameter int IN_W       = 48,
    parameter int OUT_W      = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ms3d_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ms3d_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic [IN_W-1:0]                     i_in_data,
    input  logic [1:0]                          i_in_user,
    input  ms3d_pkg::t_dp_cmd                   i_cmd,
    output ms3d_pkg::t_dp_stat                  o_stat,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [OUT_W-1:0]                    o_out_data
);
    import ms3d_pkg::*;

    localparam int VB = VALUE_BITS;
    localparam longint unsigned DEPTH = longint'(DIM_X) * DIM_Y * DIM_Z;
    localparam int AW = $clog2(DEPTH);
    localparam int MW = (VB + 3 > 17) ? VB + 3 : 17;   // delta magnitude
    localparam int SW = VB + 3;                          // neighbor sum
    localparam longint unsigned SX = longint'(DIM_Y) * DIM_Z;
    localparam longint unsigned SY = DIM_Z;
    localparam logic [VB-1:0] VMAX = '1;

    // configuration
    logic [8:0]  r_size_x;
    logic [4:0]  r_size_y;
    logic [6:0]  r_size_z;
    logic [15:0] r_gain;
    logic [15:0] r_sweeps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= 9'd256;
            r_size_y <= 5'd14;
            r_size_z <= 7'd46;
            r_gain   <= 16'd4194;
            r_sweeps <= 16'd100;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SIZE_X: r_size_x <= i_cfg_wdata[8:0];
                CFG_SIZE_Y: r_size_y <= i_cfg_wdata[4:0];
                CFG_SIZE_Z: r_size_z <= i_cfg_wdata[6:0];
                CFG_GAIN:   r_gain   <= i_cfg_wdata;
                CFG_SWEEPS: r_sweeps <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [CW-1:0] ex, ey, ez;
    assign ex = (CW'(r_size_x) > CW'(DIM_X)) ? CW'(DIM_X) : CW'(r_size_x);
    assign ey = (CW'(r_size_y) > CW'(DIM_Y)) ? CW'(DIM_Y) : CW'(r_size_y);
    assign ez = (CW'(r_size_z) > CW'(DIM_Z)) ? CW'(DIM_Z) : CW'(r_size_z);

    // host fields
    logic [PX_W-1:0] px;
    logic [PY_W-1:0] py;
    logic [PZ_W-1:0] pz;
    logic [VB-1:0]   wval;
    logic            wwall;
    t_action         act;
    logic            in_box;
    logic [AW-1:0]   host_row;
    logic [AW-1:0]   host_addr;

    assign px    = i_in_data[PX_W-1:0];
    assign py    = i_in_data[PX_W +: PY_W];
    assign pz    = i_in_data[PX_W+PY_W +: PZ_W];
    assign wval  = i_in_data[POS_W +: VB];
    assign wwall = i_in_data[POS_W+VB];
    assign act   = t_action'(i_in_user);
    assign in_box = (CW'(px) < ex) && (CW'(py) < ey) && (CW'(pz) < ez);
    assign host_row  = AW'(px) * AW'(DIM_Y) + AW'(py);
    assign host_addr = host_row * AW'(DIM_Z) + AW'(pz);

    // sweep state
    logic [CW-1:0] r_x, r_y, r_z;
    logic [AW-1:0] r_c, r_cx, r_cy;
    logic [2:0]    r_k;
    logic [SW-1:0] r_sum;
    logic [2:0]    r_cnt;
    logic [VB-1:0] r_self;
    logic          r_self_wall;
    logic          r_neg;
    logic [MW-1:0] r_mag;
    logic [31:0]   r_plo;
    logic [15:0]   r_sweep;
    logic          r_clamp;

    logic [AW-1:0] nb_addr;
    always_comb begin
        case (r_k)
            3'd0:    nb_addr = r_c;
            3'd1:    nb_addr = r_c - AW'(SX);
            3'd2:    nb_addr = r_c + AW'(SX);
            3'd3:    nb_addr = r_c - AW'(SY);
            3'd4:    nb_addr = r_c + AW'(SY);
            3'd5:    nb_addr = r_c - AW'(1);
            3'd6:    nb_addr = r_c + AW'(1);
            default: nb_addr = r_c;
        endcase
    end

    // memories
    logic          conc_we;
    logic [AW-1:0] conc_waddr, conc_raddr;
    logic [VB:0]   conc_wdata, conc_q;
    logic          dlt_we;
    logic [MW:0]   dlt_wdata, dlt_q;

    ms3d_ram #(.WIDTH(VB + 1), .DEPTH(DEPTH)) u_conc (
        .i_clk   (i_clk),
        .i_we    (conc_we),
        .i_waddr (conc_waddr),
        .i_wdata (conc_wdata),
        .i_raddr (conc_raddr),
        .o_rdata (conc_q)
    );

    ms3d_ram #(.WIDTH(MW + 1), .DEPTH(DEPTH)) u_delta (
        .i_clk   (i_clk),
        .i_we    (dlt_we),
        .i_waddr (r_c),
        .i_wdata (dlt_wdata),
        .i_raddr (r_c),
        .o_rdata (dlt_q)
    );

    // stencil arithmetic
    logic [SW-1:0] self_t;
    logic [MW-1:0] hi_prod, dscaled;
    logic [VB-1:0] q_val;
    logic          q_wall;
    logic [MW:0]   up_sum;
    logic [VB-1:0] nv;
    logic          up_clamp;

    assign q_val  = conc_q[VB-1:0];
    assign q_wall = conc_q[VB];
    assign self_t = SW'(r_cnt) * SW'(r_self);
    assign hi_prod = r_mag[MW-1:16] * r_gain;
    assign dscaled = hi_prod + MW'((r_plo + 32'h0000_8000) >> 16);

    always_comb begin
        up_sum   = (MW+1)'(q_val) + (MW+1)'(dlt_q[MW-1:0]);
        up_clamp = 1'b0;
        nv       = q_val;
        if (dlt_q[MW]) begin
            if (dlt_q[MW-1:0] > MW'(q_val)) begin
                nv       = '0;
                up_clamp = 1'b1;
            end else begin
                nv = q_val - VB'(dlt_q[MW-1:0]);
            end
        end else if (up_sum > (MW+1)'(VMAX)) begin
            nv       = VMAX;
            up_clamp = 1'b1;
        end else begin
            nv = up_sum[VB-1:0];
        end
    end

    always_comb begin
        conc_we    = 1'b0;
        conc_waddr = r_c;
        conc_wdata = {1'b0, nv};
        conc_raddr = r_c;
        case (i_cmd.op)
            CMD_HOST: begin
                conc_we    = (act == ACT_WRITE) && in_box;
                conc_waddr = host_addr;
                conc_wdata = {wwall, wval};
                conc_raddr = host_addr;
            end
            CMD_NB:    conc_raddr = nb_addr;
            CMD_UP_WR: conc_we    = !q_wall;
            default: ;
        endcase
    end

    assign dlt_we    = (i_cmd.op == CMD_MHI);
    assign dlt_wdata = r_self_wall ? '0 : {r_neg, dscaled};

    logic cell_last;
    assign cell_last = (r_x == ex - CW'(2)) && (r_y == ey - CW'(2)) && (r_z == ez - CW'(2));

    logic advance;
    assign advance = (i_cmd.op == CMD_MHI) || (i_cmd.op == CMD_UP_WR);

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            CMD_HOST: begin
                r_k     <= '0;
                r_sweep <= '0;
                r_clamp <= 1'b0;
            end
            CMD_NB: begin
                r_k <= r_k + 3'd1;
                if (r_k == 3'd1) begin
                    r_self      <= q_val;
                    r_self_wall <= q_wall;
                    r_sum       <= '0;
                    r_cnt       <= '0;
                end else if (r_k != 3'd0 && !q_wall) begin
                    r_sum <= r_sum + SW'(q_val);
                    r_cnt <= r_cnt + 3'd1;
                end
            end
            CMD_NBL: begin
                if (!q_wall) begin
                    r_sum <= r_sum + SW'(q_val);
                    r_cnt <= r_cnt + 3'd1;
                end
            end
            CMD_DIFF: begin
                r_k   <= '0;
                r_neg <= r_sum < self_t;
                r_mag <= (r_sum < self_t) ? MW'(self_t - r_sum) : MW'(r_sum - self_t);
            end
            CMD_MLO: r_plo <= r_mag[15:0] * r_gain;
            CMD_UP_WR: begin
                if (up_clamp && !q_wall) begin
                    r_clamp <= 1'b1;
                end
                if (cell_last) begin
                    r_sweep <= r_sweep + 16'd1;
                end
            end
            default: ;
        endcase

        // interior cell walk, z fastest
        if (i_cmd.op == CMD_HOST || (advance && cell_last)) begin
            r_x  <= CW'(1);
            r_y  <= CW'(1);
            r_z  <= CW'(1);
            r_cx <= AW'(SX);
            r_cy <= AW'(SX + SY);
            r_c  <= AW'(SX + SY + 1);
        end else if (advance) begin
            if (r_z != ez - CW'(2)) begin
                r_z <= r_z + CW'(1);
                r_c <= r_c + AW'(1);
            end else if (r_y != ey - CW'(2)) begin
                r_y  <= r_y + CW'(1);
                r_z  <= CW'(1);
                r_cy <= r_cy + AW'(SY);
                r_c  <= r_cy + AW'(SY + 1);
            end else begin
                r_x  <= r_x + CW'(1);
                r_y  <= CW'(1);
                r_z  <= CW'(1);
                r_cx <= r_cx + AW'(SX);
                r_cy <= r_cx + AW'(SX + SY);
                r_c  <= r_cx + AW'(SX + SY + 1);
            end
        end
    end

    // result register
    logic          r_out_valid;
    logic [VB-1:0] r_rd_value;
    logic          r_rd_wall;
    t_status       r_status;
    logic          run_trivial;
    logic          host_load;
    logic          out_load;

    assign run_trivial = (r_sweeps == 16'd0) || (ex < CW'(3)) || (ey < CW'(3))
                         || (ez < CW'(3));
    assign host_load = (i_cmd.op == CMD_HOST)
                       && !((act == ACT_READ) && in_box)
                       && !((act == ACT_RUN) && !run_trivial);
    assign out_load = host_load || (i_cmd.op == CMD_RD_RESULT)
                      || (i_cmd.op == CMD_RUN_DONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (host_load) begin
            r_rd_value <= '0;
            r_rd_wall  <= 1'b0;
            r_status   <= ((act == ACT_WRITE || act == ACT_READ) && !in_box) ? ST_RANGE : ST_OK;
        end else if (i_cmd.op == CMD_RD_RESULT) begin
            r_rd_value <= q_val;
            r_rd_wall  <= q_wall;
            r_status   <= ST_OK;
        end else if (i_cmd.op == CMD_RUN_DONE) begin
            r_rd_value <= '0;
            r_rd_wall  <= 1'b0;
            r_status   <= r_clamp ? ST_CLAMP : ST_OK;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = OUT_W'({r_status, r_rd_wall, r_rd_value});

    assign o_stat.out_free    = !r_out_valid || i_out_ready;
    assign o_stat.act         = act;
    assign o_stat.in_box      = in_box;
    assign o_stat.run_trivial = run_trivial;
    assign o_stat.k_last      = (r_k == 3'd6);
    assign o_stat.cell_last   = cell_last;
    assign o_stat.sweep_last  = ({1'b0, r_sweep} + 17'd1) == {1'b0, r_sweeps};
endmodule

/* rtl/ms3d_ctrl.sv */
module ms3d_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output ms3d_pkg::t_dp_cmd  o_cmd,
    input  ms3d_pkg::t_dp_stat i_stat
);
    import ms3d_pkg::*;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE) && i_stat.out_free;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_stat.act == ACT_READ && i_stat.in_box) begin
                        n_state = S_HOST_RD;
                    end else if (i_stat.act == ACT_RUN && !i_stat.run_trivial) begin
                        n_state = S_NB;
                    end
                end
            end
            S_HOST_RD: n_state = S_IDLE;
            S_NB:      n_state = i_stat.k_last ? S_NBL : S_NB;
            S_NBL:     n_state = S_DIFF;
            S_DIFF:    n_state = S_MLO;
            S_MLO:     n_state = S_MHI;
            S_MHI:     n_state = i_stat.cell_last ? S_UP_RD : S_NB;
            S_UP_RD:   n_state = S_UP_WR;
            S_UP_WR: begin
                if (!i_stat.cell_last) begin
                    n_state = S_UP_RD;
                end else if (i_stat.sweep_last) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_NB;
                end
            end
            S_DONE:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        case (r_state)
            S_IDLE:    o_cmd.op = accept ? CMD_HOST : CMD_NONE;
            S_HOST_RD: o_cmd.op = CMD_RD_RESULT;
            S_NB:      o_cmd.op = CMD_NB;
            S_NBL:     o_cmd.op = CMD_NBL;
            S_DIFF:    o_cmd.op = CMD_DIFF;
            S_MLO:     o_cmd.op = CMD_MLO;
            S_MHI:     o_cmd.op = CMD_MHI;
            S_UP_RD:   o_cmd.op = CMD_UP_RD;
            S_UP_WR:   o_cmd.op = CMD_UP_WR;
            S_DONE:    o_cmd.op = CMD_RUN_DONE;
            default:   o_cmd.op = CMD_NONE;
        endcase
    end

`ifndef SYNTHESIS
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready)
        else $error("input taken while a run or read is in progress");
    a_read_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOST_RD) |=> (r_state == S_IDLE))
        else $error("host read did not return to idle");
    a_done_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> i_stat.out_free)
        else $error("run finished while result register still full");
`endif
endmodule
